FILE: design/dss_pkg.sv
// shared types and constants for the dual stack shared store
`default_nettype none

package dss_pkg;

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_PEEK    = 2'd2,
      OP_DISPLAY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_OUT
   } state_type;

   localparam int unsigned DATA_W = 32;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic push;
      logic overflow;
      logic empty_rsp;
      logic read_first;
      logic read_next;
      logic load_read;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   last_out;
   } stat_type;

endpackage

`default_nettype wire

FILE: design/dss_stream_if.sv
// request and response channel interfaces
`default_nettype none

interface dss_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          operation;
   logic                                stack_select;
   logic signed [dss_pkg::DATA_W-1:0]   push_value;

   modport source (output valid, output operation, output stack_select,
                   output push_value, input ready);
   modport sink   (input valid, input operation, input stack_select,
                   input push_value, output ready);
endinterface

interface dss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic signed [dss_pkg::DATA_W-1:0]   result_value;
   logic                                last;

   modport source (output valid, output status, output result_value,
                   output last, input ready);
   modport sink   (input valid, input status, input result_value,
                   input last, output ready);
endinterface

`default_nettype wire

FILE: design/dss_ctrl.sv
// controller state machine for the dual stack shared store
`default_nettype none

module dss_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire dss_pkg::stat_type stat,
   output dss_pkg::cmd_type       cmd
);

   dss_pkg::state_type state_ff, state_in;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dss_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      rsp_valid = 1'b0;
      // a new beat may enter as the final result of the previous item leaves
      req_ready = (state_ff == dss_pkg::S_IDLE) ||
                  ((state_ff == dss_pkg::S_OUT) && rsp_ready && stat.last_out);
      accept    = req_valid && req_ready;
      cmd.capture = accept;

      unique case (state_ff)
         dss_pkg::S_IDLE: begin
            if (accept) begin
               state_in = dss_pkg::S_EXEC;
            end
         end
         dss_pkg::S_EXEC: begin
            unique case (stat.op)
               dss_pkg::OP_PUSH: begin
                  if (stat.full) begin
                     cmd.overflow = 1'b1;
                  end else begin
                     cmd.push = 1'b1;
                  end
                  state_in = dss_pkg::S_OUT;
               end
               default: begin
                  if (stat.empty) begin
                     cmd.empty_rsp = 1'b1;
                     state_in      = dss_pkg::S_OUT;
                  end else begin
                     cmd.read_first = 1'b1;
                     state_in       = dss_pkg::S_READ;
                  end
               end
            endcase
         end
         dss_pkg::S_READ: begin
            cmd.load_read = 1'b1;
            state_in      = dss_pkg::S_OUT;
         end
         dss_pkg::S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (!stat.last_out) begin
                  cmd.read_next = 1'b1;
                  state_in      = dss_pkg::S_READ;
               end else if (accept) begin
                  state_in = dss_pkg::S_EXEC;
               end else begin
                  state_in = dss_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = dss_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/dss_datapath.sv
// datapath: shared word store, stack counts, read walker and result register
`default_nettype none

module dss_datapath #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dss_pkg::cmd_type                    cmd,
   output dss_pkg::stat_type                        stat,
   input  wire logic [1:0]                          req_operation,
   input  wire logic                                req_stack_select,
   input  wire logic signed [dss_pkg::DATA_W-1:0]   req_push_value,
   output logic [1:0]                               rsp_status,
   output logic signed [dss_pkg::DATA_W-1:0]        rsp_result_value,
   output logic                                     rsp_last
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [dss_pkg::DATA_W-1:0] mem [DEPTH];

   dss_pkg::op_type            op_ff;
   logic                       sel_ff;
   logic [dss_pkg::DATA_W-1:0] value_ff;
   logic [CW-1:0]              count_a_ff, count_b_ff;
   logic [AW-1:0]              addr_ff;
   logic [CW-1:0]              rem_ff;
   logic [dss_pkg::DATA_W-1:0] rd_data_ff;
   dss_pkg::status_type        status_ff;
   logic [dss_pkg::DATA_W-1:0] result_ff;
   logic                       last_ff;

   logic [CW-1:0]              cnt_sel;
   logic [CW:0]                total;
   logic [CW-1:0]              push_addr_w, top_addr_w;
   logic [AW-1:0]              push_addr, top_addr, next_addr, rd_addr;

   always_comb begin
      cnt_sel     = sel_ff ? count_b_ff : count_a_ff;
      total       = {1'b0, count_a_ff} + {1'b0, count_b_ff};
      push_addr_w = sel_ff ? (CW'(DEPTH - 1) - count_b_ff) : count_a_ff;
      top_addr_w  = sel_ff ? (CW'(DEPTH) - count_b_ff) : (count_a_ff - CW'(1));
      push_addr   = push_addr_w[AW-1:0];
      top_addr    = top_addr_w[AW-1:0];
      // stack a walks down toward word 0, stack b walks up toward the last word
      next_addr   = sel_ff ? (addr_ff + AW'(1)) : (addr_ff - AW'(1));
      rd_addr     = cmd.read_first ? top_addr : next_addr;

      stat.op       = op_ff;
      stat.full     = (total >= (CW+1)'(DEPTH));
      stat.empty    = (cnt_sel == '0);
      stat.last_out = last_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= dss_pkg::op_type'(req_operation);
         sel_ff   <= req_stack_select;
         value_ff <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[push_addr] <= value_ff;
      end
      if (cmd.read_first || cmd.read_next) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_first || cmd.read_next) begin
         addr_ff <= rd_addr;
         rem_ff  <= cmd.read_first ? cnt_sel : (rem_ff - CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else if (cmd.push) begin
         if (sel_ff) begin
            count_b_ff <= count_b_ff + CW'(1);
         end else begin
            count_a_ff <= count_a_ff + CW'(1);
         end
      end else if (cmd.load_read && (op_ff == dss_pkg::OP_POP)) begin
         if (sel_ff) begin
            count_b_ff <= count_b_ff - CW'(1);
         end else begin
            count_a_ff <= count_a_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         status_ff <= dss_pkg::ST_OK;
         result_ff <= value_ff;
         last_ff   <= 1'b1;
      end else if (cmd.overflow) begin
         status_ff <= dss_pkg::ST_OVERFLOW;
         result_ff <= '0;
         last_ff   <= 1'b1;
      end else if (cmd.empty_rsp) begin
         status_ff <= dss_pkg::ST_EMPTY;
         result_ff <= '0;
         last_ff   <= 1'b1;
      end else if (cmd.load_read) begin
         status_ff <= dss_pkg::ST_OK;
         result_ff <= rd_data_ff;
         last_ff   <= (op_ff != dss_pkg::OP_DISPLAY) || (rem_ff == CW'(1));
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_result_value = result_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

FILE: design/dual_stack_shared_store_top.sv
// top level of the dual stack shared store
// Two stacks share one store of DEPTH 32-bit words: stack a grows up from
// word 0, stack b grows down from word DEPTH-1.
// req_bus carries one beat per request (operation, stack_select, push_value);
// rsp_bus returns result beats (status, result_value, last).
// Push and all error results are registered in the execute state after the
// request beat is captured. Pop and peek also issue the store read there,
// and the read state registers the read data into the result register.
// Display gives its first element like pop and peek; once an element is
// taken, the next is read from the store, one store read per element.
// One request is in flight at a time; a new request is taken in the same
// cycle that the final result beat of the previous one is taken.
// Reset empties both stacks and clears the controller; store contents are
// left as they are. While the receiver holds rsp_bus.ready low the result
// beat stays registered and stable and no new request is taken.
`default_nettype none

module dual_stack_shared_store_top #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dss_req_if.sink    req_bus,
   dss_rsp_if.source  rsp_bus
);

   dss_pkg::cmd_type  cmd;
   dss_pkg::stat_type stat;

   dss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dss_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_bus.operation),
      .req_stack_select (req_bus.stack_select),
      .req_push_value   (req_bus.push_value),
      .rsp_status       (rsp_bus.status),
      .rsp_result_value (rsp_bus.result_value),
      .rsp_last         (rsp_bus.last)
   );

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench for the dual stack shared store: random push, pop, peek and display traffic
`default_nettype none

class stack_mirror #(int unsigned DEPTH = 16);

   typedef struct packed {
      dss_pkg::status_type status;
      logic [31:0]         value;
      logic                last;
   } result_beat;

   logic [31:0]  words [DEPTH];
   int unsigned  count_a;
   int unsigned  count_b;
   result_beat   pending_results[$];
   int unsigned  failures;

   function new();
      count_a  = 0;
      count_b  = 0;
      failures = 0;
   endfunction

   function bit is_full();
      return count_a + count_b >= DEPTH;
   endfunction

   // word holding the element at depth d (0 = top) of the chosen stack
   function int unsigned slot(logic sel, int unsigned d);
      return sel ? DEPTH - count_b + d : count_a - 1 - d;
   endfunction

   function void queue_beat(dss_pkg::status_type status, logic [31:0] value, logic last);
      result_beat beat;
      beat.status = status;
      beat.value  = value;
      beat.last   = last;
      pending_results.push_back(beat);
   endfunction

   function void note_request(dss_pkg::op_type op, logic sel, logic [31:0] val);
      int unsigned height;
      height = sel ? count_b : count_a;
      if (op == dss_pkg::OP_PUSH) begin
         if (is_full()) begin
            queue_beat(dss_pkg::ST_OVERFLOW, 32'd0, 1'b1);
         end else begin
            if (!sel) begin
               words[count_a] = val;
               count_a++;
            end else begin
               count_b++;
               words[DEPTH - count_b] = val;
            end
            queue_beat(dss_pkg::ST_OK, val, 1'b1);
         end
      end else if (height == 0) begin
         queue_beat(dss_pkg::ST_EMPTY, 32'd0, 1'b1);
      end else if (op == dss_pkg::OP_DISPLAY) begin
         for (int unsigned d = 0; d < height; d++)
            queue_beat(dss_pkg::ST_OK, words[slot(sel, d)], d + 1 == height);
      end else begin
         queue_beat(dss_pkg::ST_OK, words[slot(sel, 0)], 1'b1);
         if (op == dss_pkg::OP_POP) begin
            if (!sel) count_a--;
            else count_b--;
         end
      end
   endfunction

   function void check_result(logic [1:0] status, logic [31:0] value, logic last);
      result_beat want;
      if (pending_results.size() == 0) begin
         $error("result beat with nothing expected: status %0d value %0d last %0d",
                status, $signed(value), last);
         failures++;
         return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, status);
         failures++;
      end
      if (value !== want.value) begin
         $error("result_value: expected %0d, actual %0d",
                $signed(want.value), $signed(value));
         failures++;
      end
      if (last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, last);
         failures++;
      end
   endfunction

endclass

module tb;

   localparam int unsigned STORE_DEPTH = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_ITEMS = 500;

   logic clock;
   logic reset;
   logic no_gaps;
   int unsigned cycle_count;
   int unsigned sent;

   dss_req_if req_bus ();
   dss_rsp_if rsp_bus ();

   stack_mirror #(STORE_DEPTH) mirror;

   dual_stack_shared_store_top #(.DEPTH(STORE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= no_gaps || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         mirror.check_result(rsp_bus.status, rsp_bus.result_value, rsp_bus.last);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // called at a rising edge; returns at the edge where the beat was taken
   task automatic send_request(dss_pkg::op_type op, logic sel, logic [31:0] val);
      int unsigned gap;
      gap = 0;
      if (!no_gaps && $urandom_range(99) < 12) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= op;
      req_bus.stack_select <= sel;
      req_bus.push_value   <= val;
      do @(posedge clock); while (!req_bus.ready);
      mirror.note_request(op, sel, val);
      sent++;
   endtask

   task automatic fill_burst();
      while (!mirror.is_full())
         send_request(dss_pkg::OP_PUSH, 1'($urandom_range(1)), rand_word());
      repeat ($urandom_range(1, 2))
         send_request(dss_pkg::OP_PUSH, 1'($urandom_range(1)), rand_word());
      send_request(dss_pkg::OP_DISPLAY, 1'b0, rand_word());
      send_request(dss_pkg::OP_DISPLAY, 1'b1, rand_word());
   endtask

   task automatic drain_burst();
      logic sel;
      while (mirror.count_a + mirror.count_b > 0) begin
         sel = 1'($urandom_range(1));
         send_request(dss_pkg::op_type'(($urandom_range(3) == 0) ?
                                        dss_pkg::OP_PEEK : dss_pkg::OP_POP),
                      sel, rand_word());
      end
      send_request(dss_pkg::OP_POP, 1'($urandom_range(1)), rand_word());
   endtask

   task automatic mixed_burst();
      repeat ($urandom_range(10, 30))
         send_request(dss_pkg::op_type'($urandom_range(3)), 1'($urandom_range(1)),
                      rand_word());
   endtask

   initial begin
      int unsigned goal;
      mirror               = new();
      clock                = 1'b0;
      reset                = 1'b1;
      no_gaps              = 1'b0;
      cycle_count          = 0;
      sent                 = 0;
      req_bus.valid        = 1'b0;
      req_bus.operation    = dss_pkg::OP_PUSH;
      req_bus.stack_select = 1'b0;
      req_bus.push_value   = '0;
      rsp_bus.ready        = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty stacks first, then extreme values on both sides
      send_request(dss_pkg::OP_POP, 1'b0, 32'h0);
      send_request(dss_pkg::OP_PEEK, 1'b1, 32'h0);
      send_request(dss_pkg::OP_DISPLAY, 1'b0, 32'h0);
      send_request(dss_pkg::OP_DISPLAY, 1'b1, 32'hffff_ffff);
      send_request(dss_pkg::OP_PUSH, 1'b0, 32'h8000_0000);
      send_request(dss_pkg::OP_PUSH, 1'b1, 32'h7fff_ffff);
      send_request(dss_pkg::OP_PUSH, 1'b0, 32'h7fff_ffff);
      send_request(dss_pkg::OP_PUSH, 1'b1, 32'h8000_0000);
      send_request(dss_pkg::OP_PEEK, 1'b0, 32'h0);
      send_request(dss_pkg::OP_PEEK, 1'b1, 32'h0);
      send_request(dss_pkg::OP_DISPLAY, 1'b0, 32'h0);
      send_request(dss_pkg::OP_DISPLAY, 1'b1, 32'h0);
      send_request(dss_pkg::OP_POP, 1'b0, 32'h0);
      send_request(dss_pkg::OP_POP, 1'b1, 32'h0);
      send_request(dss_pkg::OP_POP, 1'b1, 32'h0);
      send_request(dss_pkg::OP_PEEK, 1'b1, 32'h0);

      goal = sent + RANDOM_ITEMS;
      while (sent < goal) begin
         // a long stretch in the middle runs with both sides at full rate
         no_gaps = (sent > goal - RANDOM_ITEMS / 2) && (sent < goal - RANDOM_ITEMS / 4);
         case ($urandom_range(9))
            0, 1:    fill_burst();
            2, 3:    drain_burst();
            default: mixed_burst();
         endcase
      end
      no_gaps = 1'b0;
      req_bus.valid <= 1'b0;

      while (mirror.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mirror.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
